### design/rwsr_pkg.sv
// Shared types, constants and register codes of the roll waveform span renderer.
// Used by rwsr_cfg, rwsr_line and the top module; depends on nothing.
`timescale 1ns / 1ps

package rwsr_pkg;

	localparam int RWSR_RING_DEPTH_DEF = 512;
	localparam int RWSR_ADDR_W         = 5;
	localparam int RWSR_DATA_W         = 32;
	localparam int RWSR_SAMPLE_W       = 16;
	localparam int RWSR_COL_W          = 9;
	localparam int RWSR_ROW_W          = 9;
	localparam int RWSR_X_W            = 10;
	localparam int RWSR_COLOR_W        = 16;
	localparam int RWSR_PROD_W         = 24;

	localparam logic [RWSR_SAMPLE_W-1:0] RWSR_SIGN_FLIP  = 16'h8000;
	localparam logic [16:0]              RWSR_FULL_SCALE = 17'd65535;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_RENDER = 1'b1;

	localparam logic CH_FIRST  = 1'b0;
	localparam logic CH_SECOND = 1'b1;

	localparam logic [8:0]  RST_AREA_WIDTH  = 9'd320;
	localparam logic [7:0]  RST_AREA_HEIGHT = 8'd240;

	typedef enum logic [2:0] {
		REG_LEFT_EDGE,
		REG_TOP_EDGE,
		REG_AREA_WIDTH,
		REG_AREA_HEIGHT,
		REG_FIRST_COLOR,
		REG_SECOND_COLOR,
		REG_FIRST_ENABLE,
		REG_SECOND_ENABLE
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_CURR,
		ST_MUL,
		ST_ROW,
		ST_RUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [8:0]              left_edge;
		logic [7:0]              top_edge;
		logic [8:0]              area_width;
		logic [7:0]              area_height;
		logic [RWSR_COLOR_W-1:0] first_color;
		logic [RWSR_COLOR_W-1:0] second_color;
		logic                    first_enable;
		logic                    second_enable;
	} cfg_t;

	typedef struct packed {
		logic mul;
		logic row;
		logic run;
	} line_ctl_t;

	typedef struct packed {
		logic [RWSR_ROW_W-1:0] y0;
		logic [RWSR_ROW_W-1:0] y1;
		logic [RWSR_ROW_W-1:0] y2;
		logic [RWSR_ROW_W-1:0] y3;
	} run_t;

endpackage

### design/rwsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module rwsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/rwsr_cfg.sv
// APB-style configuration registers of the span renderer.
// Depends on rwsr_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module rwsr_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rwsr_pkg::RWSR_ADDR_W-1:0]     paddr,
	input  logic [rwsr_pkg::RWSR_DATA_W-1:0]     pwdata,
	output logic [rwsr_pkg::RWSR_DATA_W-1:0]     prdata,
	output logic                                 pready,
	output rwsr_pkg::cfg_t                       cfg
);

	import rwsr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[RWSR_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_edge     <= '0;
			cfg_q.top_edge      <= '0;
			cfg_q.area_width    <= RST_AREA_WIDTH;
			cfg_q.area_height   <= RST_AREA_HEIGHT;
			cfg_q.first_color   <= '0;
			cfg_q.second_color  <= '0;
			cfg_q.first_enable  <= 1'b1;
			cfg_q.second_enable <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_LEFT_EDGE:     cfg_q.left_edge     <= pwdata[8:0];
				REG_TOP_EDGE:      cfg_q.top_edge      <= pwdata[7:0];
				REG_AREA_WIDTH:    cfg_q.area_width    <= pwdata[8:0];
				REG_AREA_HEIGHT:   cfg_q.area_height   <= pwdata[7:0];
				REG_FIRST_COLOR:   cfg_q.first_color   <= pwdata[RWSR_COLOR_W-1:0];
				REG_SECOND_COLOR:  cfg_q.second_color  <= pwdata[RWSR_COLOR_W-1:0];
				REG_FIRST_ENABLE:  cfg_q.first_enable  <= pwdata[0];
				REG_SECOND_ENABLE: cfg_q.second_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_LEFT_EDGE:     prdata = RWSR_DATA_W'(cfg_q.left_edge);
			REG_TOP_EDGE:      prdata = RWSR_DATA_W'(cfg_q.top_edge);
			REG_AREA_WIDTH:    prdata = RWSR_DATA_W'(cfg_q.area_width);
			REG_AREA_HEIGHT:   prdata = RWSR_DATA_W'(cfg_q.area_height);
			REG_FIRST_COLOR:   prdata = RWSR_DATA_W'(cfg_q.first_color);
			REG_SECOND_COLOR:  prdata = RWSR_DATA_W'(cfg_q.second_color);
			REG_FIRST_ENABLE:  prdata = RWSR_DATA_W'(cfg_q.first_enable);
			REG_SECOND_ENABLE: prdata = RWSR_DATA_W'(cfg_q.second_enable);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### design/rwsr_line.sv
// One channel of the renderer: scales a sample pair to rows and splits the
// two-column line into its vertical runs. Depends on rwsr_pkg.
`timescale 1ns / 1ps

module rwsr_line (
	input  logic                                clk,
	input  rwsr_pkg::line_ctl_t                 ctl,
	input  logic [7:0]                          area_height,
	input  logic [7:0]                          top_edge,
	input  logic [rwsr_pkg::RWSR_SAMPLE_W-1:0]  prev_sample,
	input  logic [rwsr_pkg::RWSR_SAMPLE_W-1:0]  curr_sample,
	output rwsr_pkg::run_t                      runs
);

	import rwsr_pkg::*;

	logic [7:0]             h1;
	logic [RWSR_PROD_W-1:0] p_prev_s1, p_curr_s1;
	logic [RWSR_ROW_W-1:0]  ya_s2, yb_s2;
	run_t                   runs_s3;
	logic [RWSR_ROW_W-1:0]  dy, half, r1, r2;
	logic                   up;

	// row = top + h1 - floor(p / 65535), p below 2^24
	function automatic logic [RWSR_ROW_W-1:0] row_of(
		input logic [RWSR_PROD_W-1:0] p,
		input logic [7:0]             top,
		input logic [7:0]             hm1
	);
		logic [7:0]  q0;
		logic [16:0] rem;
		logic [8:0]  q;
		q0     = p[RWSR_PROD_W-1:16];
		rem    = {1'b0, p[15:0]} + {9'b0, q0};
		q      = {1'b0, q0} + {8'b0, (rem >= RWSR_FULL_SCALE)};
		row_of = {1'b0, top} + {1'b0, hm1} - q;
	endfunction

	assign h1 = area_height - 8'd1;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			p_prev_s1 <= {8'b0, prev_sample ^ RWSR_SIGN_FLIP} * {16'b0, h1};
			p_curr_s1 <= {8'b0, curr_sample ^ RWSR_SIGN_FLIP} * {16'b0, h1};
		end
		if (ctl.row) begin
			ya_s2 <= row_of(p_prev_s1, top_edge, h1);
			yb_s2 <= row_of(p_curr_s1, top_edge, h1);
		end
		if (ctl.run) begin
			runs_s3.y0 <= ya_s2;
			runs_s3.y1 <= r1;
			runs_s3.y2 <= r2;
			runs_s3.y3 <= yb_s2;
		end
	end

	// split the climb at its midpoint, the second run opens one row past it (same row when flat)
	always_comb begin
		up   = yb_s2 > ya_s2;
		dy   = up ? (yb_s2 - ya_s2) : (ya_s2 - yb_s2);
		half = dy >> 1;
		if (up) begin
			r1 = ya_s2 + half;
			r2 = ya_s2 + half + RWSR_ROW_W'(1);
		end else if (dy == '0) begin
			r1 = ya_s2;
			r2 = ya_s2;
		end else begin
			r1 = ya_s2 - half;
			r2 = ya_s2 - half - RWSR_ROW_W'(1);
		end
	end

	assign runs = runs_s3;

endmodule

### design/roll_waveform_span_renderer_top.sv
// Channel    Handshake                    Carries
// item       item_valid / item_stall      func, first_sample, second_sample, column
// span       span_valid / span_stall      span_x, span_y_first, span_y_final, colour, channel, last
// config     APB write at psel&penable    eight registers at byte address 4*i
//
// An add request writes the ring at the accept edge.
// A render request steps through two ring reads on the single read port, multiply, row
// scaling and run split, then emits its spans; item_stall stays high until the last one.
// Reset clears write index, fill count and state, loads register defaults; ring contents stay
// undefined until written. Span stall holds the output register and the sequencer.
// Depends on rwsr_pkg, rwsr_cfg, rwsr_ram and rwsr_line.
`timescale 1ns / 1ps

module roll_waveform_span_renderer_top #(
	parameter int RING_DEPTH = rwsr_pkg::RWSR_RING_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 func,
	input  logic signed [rwsr_pkg::RWSR_SAMPLE_W-1:0] first_sample,
	input  logic signed [rwsr_pkg::RWSR_SAMPLE_W-1:0] second_sample,
	input  logic [rwsr_pkg::RWSR_COL_W-1:0]      column,
	output logic                                 span_valid,
	input  logic                                 span_stall,
	output logic [rwsr_pkg::RWSR_X_W-1:0]        span_x,
	output logic [rwsr_pkg::RWSR_ROW_W-1:0]      span_y_first,
	output logic [rwsr_pkg::RWSR_ROW_W-1:0]      span_y_final,
	output logic [rwsr_pkg::RWSR_COLOR_W-1:0]    span_color,
	output logic                                 span_channel,
	output logic                                 span_last,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rwsr_pkg::RWSR_ADDR_W-1:0]     paddr,
	input  logic [rwsr_pkg::RWSR_DATA_W-1:0]     pwdata,
	output logic [rwsr_pkg::RWSR_DATA_W-1:0]     prdata,
	output logic                                 pready
);

	import rwsr_pkg::*;

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int T_W    = IDX_W + 2;
	localparam logic [T_W-1:0]    DEPTH_T  = T_W'(RING_DEPTH);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL     = FILL_W'(RING_DEPTH);

	cfg_t      cfg;
	state_t    state_q, state_d;
	line_ctl_t ctl;

	logic [IDX_W-1:0]  wi_q, ip_q, ip_now, ic;
	logic [FILL_W-1:0] fill_q;
	logic [RWSR_X_W-1:0] xp_q;
	logic [RWSR_COL_W-1:0] drawn;
	logic [T_W-1:0]    t, ip_full;
	logic [10:0]       xp_now;
	logic [RWSR_DATA_W-1:0] rdata, prev_q;
	logic              accept, add_go, render_ok, render_go;
	logic              rd_curr, prev_load, emit_load, emit_last;
	logic              ch_q, k_q;
	run_t              runs0, runs1, run_sel;

	logic                    span_valid_q;
	logic [RWSR_X_W-1:0]     span_x_q;
	logic [RWSR_ROW_W-1:0]   span_y_first_q, span_y_final_q;
	logic [RWSR_COLOR_W-1:0] span_color_q;
	logic                    span_channel_q, span_last_q;

	rwsr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept    = item_valid & ~item_stall;
	assign add_go    = accept & (func == FUNC_ADD);
	assign render_go = accept & (func == FUNC_RENDER) & render_ok;

	// render check, and address and column of the previous sample, straight from the request
	always_comb begin
		drawn = (fill_q < FILL_W'(cfg.area_width)) ? fill_q[RWSR_COL_W-1:0]
		                                            : cfg.area_width;
		render_ok = (fill_q >= FILL_W'(2)) && (cfg.area_width >= 9'd2)
		         && (cfg.area_height >= 8'd2) && (column != '0) && (column < drawn)
		         && (cfg.first_enable || cfg.second_enable);
		t       = {2'b00, wi_q} + T_W'(column) - T_W'(drawn) - T_W'(1);
		ip_full = t[T_W-1] ? (t + DEPTH_T) : t;
		ip_now  = ip_full[IDX_W-1:0];
		xp_now  = {2'b00, cfg.left_edge} + {2'b00, cfg.area_width} - {2'b00, drawn}
		        + {2'b00, column} - 11'd1;
	end

	assign ic = (ip_q == LAST_IDX) ? '0 : (ip_q + IDX_W'(1));

	rwsr_ram #(
		.WIDTH (RWSR_DATA_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (add_go),
		.waddr (wi_q),
		.wdata ({second_sample, first_sample}),
		.raddr (rd_curr ? ic : ip_now),
		.rdata (rdata)
	);

	rwsr_line u_line0 (
		.clk         (clk),
		.ctl         (ctl),
		.area_height (cfg.area_height),
		.top_edge    (cfg.top_edge),
		.prev_sample (prev_q[RWSR_SAMPLE_W-1:0]),
		.curr_sample (rdata[RWSR_SAMPLE_W-1:0]),
		.runs        (runs0)
	);

	rwsr_line u_line1 (
		.clk         (clk),
		.ctl         (ctl),
		.area_height (cfg.area_height),
		.top_edge    (cfg.top_edge),
		.prev_sample (prev_q[RWSR_DATA_W-1:RWSR_SAMPLE_W]),
		.curr_sample (rdata[RWSR_DATA_W-1:RWSR_SAMPLE_W]),
		.runs        (runs1)
	);

	assign run_sel   = (ch_q == CH_SECOND) ? runs1 : runs0;
	assign emit_last = k_q & ((ch_q == CH_SECOND) | ~cfg.second_enable);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (render_go) state_d = ST_READ_CURR;
			ST_READ_CURR: state_d = ST_MUL;
			ST_MUL:       state_d = ST_ROW;
			ST_ROW:       state_d = ST_RUN;
			ST_RUN:       state_d = ST_EMIT;
			ST_EMIT:      if (emit_load && emit_last) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		rd_curr    = 1'b0;
		prev_load  = 1'b0;
		ctl        = '0;
		emit_load  = 1'b0;
		case (state_q)
			ST_IDLE:      item_stall = 1'b0;
			ST_READ_CURR: begin
				rd_curr   = 1'b1;
				prev_load = 1'b1;
			end
			ST_MUL:       ctl.mul = 1'b1;
			ST_ROW:       ctl.row = 1'b1;
			ST_RUN:       ctl.run = 1'b1;
			ST_EMIT:      emit_load = ~span_valid_q | ~span_stall;
			default:      item_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wi_q    <= '0;
			fill_q  <= '0;
			ch_q    <= CH_FIRST;
			k_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (add_go) begin
				wi_q <= (wi_q == LAST_IDX) ? '0 : (wi_q + IDX_W'(1));
				if (fill_q != FULL) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (render_go) begin
				ch_q <= cfg.first_enable ? CH_FIRST : CH_SECOND;
				k_q  <= 1'b0;
			end else if (emit_load) begin
				if (!k_q) begin
					k_q <= 1'b1;
				end else begin
					ch_q <= CH_SECOND;
					k_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (render_go) begin
			ip_q <= ip_now;
			xp_q <= xp_now[RWSR_X_W-1:0];
		end
		if (prev_load) begin
			prev_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit_load) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			span_x_q       <= xp_q + RWSR_X_W'(k_q);
			span_y_first_q <= k_q ? run_sel.y2 : run_sel.y0;
			span_y_final_q <= k_q ? run_sel.y3 : run_sel.y1;
			span_color_q   <= (ch_q == CH_SECOND) ? cfg.second_color : cfg.first_color;
			span_channel_q <= ch_q;
			span_last_q    <= emit_last;
		end
	end

	assign span_valid   = span_valid_q;
	assign span_x       = span_x_q;
	assign span_y_first = span_y_first_q;
	assign span_y_final = span_y_final_q;
	assign span_color   = span_color_q;
	assign span_channel = span_channel_q;
	assign span_last    = span_last_q;

endmodule
